// ===== hdl/acbe_pkg.sv =====
package acbe_pkg;

  localparam int unsigned POS_W        = 7;
  localparam int unsigned BLEFT_W      = 7;
  localparam int unsigned CFG_ADDR_W   = 8;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
  localparam logic [POS_W-1:0] POS_SDID     = 7'd1;
  localparam logic [POS_W-1:0] POS_CC_COUNT = 7'd11;

  localparam logic [CFG_ADDR_W-1:0] CFG_DID_IDX  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SDID_IDX = 8'd1;

  localparam logic [7:0] DID_RESET  = 8'h61;
  localparam logic [7:0] SDID_RESET = 8'h01;

  typedef struct packed {
    logic       func;
    logic [9:0] anc_word;
    logic       packet_start;
  } item_t;

  typedef struct packed {
    logic [7:0] cc_byte;
    logic [8:0] byte_index;
    logic       byte_valid;
    logic       frame_done;
    logic [9:0] frame_bytes;
    logic       frame_overflow;
  } result_t;

  typedef struct packed {
    logic [7:0] did;
    logic [7:0] sdid;
  } cfg_t;

endpackage

// ===== hdl/acbe_if.sv =====
interface acbe_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [9:0] anc_word;
  logic       packet_start;

  modport source (output valid, func, anc_word, packet_start, input ready);
  modport sink   (input valid, func, anc_word, packet_start, output ready);
endinterface

interface acbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cc_byte;
  logic [8:0] byte_index;
  logic       byte_valid;
  logic       frame_done;
  logic [9:0] frame_bytes;
  logic       frame_overflow;

  modport source (output valid, cc_byte, byte_index, byte_valid, frame_done, frame_bytes,
                  frame_overflow, input ready);
  modport sink   (input valid, cc_byte, byte_index, byte_valid, frame_done, frame_bytes,
                  frame_overflow, output ready);
endinterface

interface acbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] addr;
  logic [7:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hdl/anc_caption_byte_extractor.sv =====
// Caption byte extractor for ancillary data packets.
// A result passes through the input register, then the output register.
// Throughput: one input item per cycle unless out_ch.ready stalls the output register.
// Reset: rst_n is synchronous, active low; it clears packet and frame state,
// empties both pipeline registers and loads DID 0x61 and SDID 0x01.
module anc_caption_byte_extractor #(
  parameter int unsigned FRAME_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  acbe_in_if.sink     in_ch,
  acbe_out_if.source  out_ch,
  acbe_cfg_if.sink    cfg_ch
);
  import acbe_pkg::*;

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r, s1_valid_nxt;
  result_t out_res_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res;
  logic    res_valid;
  logic    out_free;
  logic    s1_adv;
  logic    in_fire;

  acbe_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  acbe_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_adv),
    .item      (s1_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free     = ~out_valid_r | out_ch.ready;
  assign s1_adv       = s1_valid_r & out_free;
  assign in_ch.ready  = ~s1_valid_r | out_free;
  assign in_fire      = in_ch.valid & in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.func         <= in_ch.func;
      s1_item_r.anc_word     <= in_ch.anc_word;
      s1_item_r.packet_start <= in_ch.packet_start;
    end
    if (s1_adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cc_byte        = out_res_r.cc_byte;
  assign out_ch.byte_index     = out_res_r.byte_index;
  assign out_ch.byte_valid     = out_res_r.byte_valid;
  assign out_ch.frame_done     = out_res_r.frame_done;
  assign out_ch.frame_bytes    = out_res_r.frame_bytes;
  assign out_ch.frame_overflow = out_res_r.frame_overflow;

`ifndef SYNTHESIS
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.byte_valid ^ out_ch.frame_done))
    else $error("result is neither or both of byte and frame end");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.byte_valid |-> (out_ch.frame_bytes == 10'd0) && !out_ch.frame_overflow)
    else $error("byte result carries frame fields");

  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item not held in input register");
`endif

endmodule

// ===== hdl/acbe_cfg_regs.sv =====
module acbe_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  acbe_cfg_if.sink      cfg_ch,
  output acbe_pkg::cfg_t cfg
);
  import acbe_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_fire;

  assign cfg_ch.ready = 1'b1;
  assign wr_fire      = cfg_ch.valid & cfg_ch.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_fire) begin
      if (cfg_ch.addr == CFG_DID_IDX) begin
        cfg_nxt.did = cfg_ch.data;
      end else if (cfg_ch.addr == CFG_SDID_IDX) begin
        cfg_nxt.sdid = cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.did  <= DID_RESET;
      cfg_r.sdid <= SDID_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/acbe_parser.sv =====
module acbe_parser #(
  parameter int unsigned FRAME_BYTES = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  acbe_pkg::item_t  item,
  input  acbe_pkg::cfg_t   cfg,
  output logic             res_valid,
  output acbe_pkg::result_t res
);
  import acbe_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned EXT_W = (CNT_W > 10) ? CNT_W : 10;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BYTES);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BLEFT_W-1:0] bleft_r, bleft_nxt;
  logic               match_r, match_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;

  logic [7:0]         low;
  logic [EXT_W-1:0]   cnt_ext;
  logic [BLEFT_W-1:0] cc_times3;

  assign low       = item.anc_word[7:0];
  assign cnt_ext   = EXT_W'(cnt_r);
  assign cc_times3 = (BLEFT_W'(item.anc_word[4:0]) << 1) + BLEFT_W'(item.anc_word[4:0]);

  always_comb begin
    pos_nxt   = pos_r;
    bleft_nxt = bleft_r;
    match_nxt = match_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    res       = '0;
    res_valid = 1'b0;
    if (item.func) begin
      res.frame_done     = 1'b1;
      res.frame_bytes    = cnt_ext[9:0];
      res.frame_overflow = ovf_r;
      res_valid          = 1'b1;
      cnt_nxt            = '0;
      ovf_nxt            = 1'b0;
      match_nxt          = 1'b0;
      bleft_nxt          = '0;
      pos_nxt            = '0;
    end else if (item.packet_start) begin
      match_nxt = (low == cfg.did);
      bleft_nxt = '0;
      pos_nxt   = POS_SDID;
    end else if (match_r) begin
      pos_nxt = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : POS_MAX;
      if (pos_r == POS_SDID) begin
        match_nxt = (low == cfg.sdid);
      end else if (pos_r < POS_CC_COUNT) begin
        match_nxt = match_r;
      end else if (pos_r == POS_CC_COUNT) begin
        bleft_nxt = cc_times3;
        if (cc_times3 == '0) begin
          match_nxt = 1'b0;
        end
      end else if (bleft_r == '0) begin
        match_nxt = 1'b0;
      end else begin
        bleft_nxt = bleft_r - BLEFT_W'(1);
        if (bleft_r == BLEFT_W'(1)) begin
          match_nxt = 1'b0;
        end
        if (cnt_r == CNT_FULL) begin
          ovf_nxt = 1'b1;
        end else begin
          res.cc_byte    = low;
          res.byte_index = cnt_ext[8:0];
          res.byte_valid = 1'b1;
          res_valid      = 1'b1;
          cnt_nxt        = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      bleft_r <= '0;
      match_r <= 1'b0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      bleft_r <= bleft_nxt;
      match_r <= match_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== bench/acbe_tb_pkg.sv =====
`timescale 1ns / 1ps

package acbe_tb_pkg;
  import acbe_pkg::*;

  class caption_tracker;
    result_t owed[$];
    logic [7:0] did_sel;
    logic [7:0] sdid_sel;
    logic [POS_W-1:0] next_pos;
    logic [BLEFT_W-1:0] bytes_owed;
    logic in_caption;
    logic [15:0] frame_fill;
    logic frame_dropped;
    int unsigned frame_limit;
    int unsigned mismatches;

    function new(int unsigned limit);
      frame_limit = limit;
      mismatches = 0;
      did_sel = DID_RESET;
      sdid_sel = SDID_RESET;
      next_pos = '0;
      bytes_owed = '0;
      in_caption = 1'b0;
      frame_fill = '0;
      frame_dropped = 1'b0;
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_DID_IDX) begin
        did_sel = val;
      end else if (idx == CFG_SDID_IDX) begin
        sdid_sel = val;
      end
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction

    function void take_word(item_t it);
      result_t r;
      logic [7:0] low;
      logic [POS_W-1:0] pos;
      low = it.anc_word[7:0];
      r = '0;
      if (it.func) begin
        r.frame_done = 1'b1;
        r.frame_bytes = frame_fill[9:0];
        r.frame_overflow = frame_dropped;
        owed.push_back(r);
        frame_fill = '0;
        frame_dropped = 1'b0;
        in_caption = 1'b0;
        bytes_owed = '0;
        next_pos = '0;
        return;
      end
      if (it.packet_start) begin
        in_caption = (low == did_sel);
        bytes_owed = '0;
        next_pos = 7'd1;
        return;
      end
      if (!in_caption) return;
      pos = next_pos;
      if (pos < POS_MAX) next_pos = pos + 7'd1;
      if (pos == POS_SDID) begin
        in_caption = (low == sdid_sel);
        return;
      end
      if (pos < POS_CC_COUNT) return;
      if (pos == POS_CC_COUNT) begin
        bytes_owed = BLEFT_W'(3 * it.anc_word[4:0]);
        if (bytes_owed == 0) in_caption = 1'b0;
        return;
      end
      if (bytes_owed == 0) begin
        in_caption = 1'b0;
        return;
      end
      bytes_owed = bytes_owed - 7'd1;
      if (bytes_owed == 0) in_caption = 1'b0;
      if (frame_fill >= frame_limit) begin
        frame_dropped = 1'b1;
        return;
      end
      r.cc_byte = low;
      r.byte_index = frame_fill[8:0];
      r.byte_valid = 1'b1;
      owed.push_back(r);
      frame_fill = frame_fill + 16'd1;
    endfunction

    function void check_output(result_t got);
      result_t exp;
      bit bad;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: byte=%h idx=%0d bv=%b fd=%b fb=%0d ov=%b",
                   got.cc_byte, got.byte_index, got.byte_valid, got.frame_done,
                   got.frame_bytes, got.frame_overflow);
        return;
      end
      exp = owed.pop_front();
      bad = (got.cc_byte !== exp.cc_byte) || (got.byte_index !== exp.byte_index) ||
            (got.byte_valid !== exp.byte_valid) || (got.frame_done !== exp.frame_done) ||
            (got.frame_bytes !== exp.frame_bytes) ||
            (got.frame_overflow !== exp.frame_overflow);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: byte=%h idx=%0d bv=%b fd=%b fb=%0d ov=%b",
                   exp.cc_byte, exp.byte_index, exp.byte_valid, exp.frame_done,
                   exp.frame_bytes, exp.frame_overflow);
          $display("         got: byte=%h idx=%0d bv=%b fd=%b fb=%0d ov=%b",
                   got.cc_byte, got.byte_index, got.byte_valid, got.frame_done,
                   got.frame_bytes, got.frame_overflow);
        end
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import acbe_pkg::*;
  import acbe_tb_pkg::*;

  localparam int unsigned FRAME_LIMIT = 512;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE = 8;

  logic clk = 1'b0;
  logic rst_n;

  acbe_in_if in_ch();
  acbe_out_if out_ch();
  acbe_cfg_if cfg_ch();

  anc_caption_byte_extractor #(.FRAME_BYTES(FRAME_LIMIT)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  caption_tracker board;
  bit quiet;
  bit hold_request;
  bit hold_off;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned useful_items;
  logic [7:0] cur_did;
  logic [7:0] cur_sdid;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : receiver
    int unsigned stall_left;
    result_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.cc_byte, out_ch.byte_index, out_ch.byte_valid, out_ch.frame_done,
               out_ch.frame_bytes, out_ch.frame_overflow};
        board.check_output(got);
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(99, 0) < rx_stall_pct) begin
        stall_left = $urandom_range(15, 0);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : long_hold
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(input logic func_bit, input logic [9:0] word, input logic start,
                           input bit useful);
    item_t it;
    it.func = func_bit;
    it.anc_word = word;
    it.packet_start = start;
    if (!quiet && !hold_off && tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func_bit;
    in_ch.anc_word <= word;
    in_ch.packet_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    board.take_word(it);
    if (useful) useful_items++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_register(idx, val);
  endtask

  task automatic configure(input logic [7:0] did, input logic [7:0] sdid);
    write_reg(CFG_DID_IDX, did);
    write_reg(CFG_SDID_IDX, sdid);
    cfg_ch.valid <= 1'b0;
    cur_did = did;
    cur_sdid = sdid;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_cc();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 10) return 5'd0;
    if (r < 85) return 5'($urandom_range(8, 1));
    return 5'($urandom_range(31, 9));
  endfunction

  task automatic send_packet(input logic [7:0] did, input logic [7:0] sdid,
                             input logic [4:0] cc, input int cut);
    int total;
    int k;
    logic [9:0] w;
    logic [1:0] hi2;
    logic [4:0] hi5;
    total = 12 + 3 * cc;
    for (k = 0; k < total; k++) begin
      if (k == cut) return;
      hi2 = 2'($urandom_range(3, 0));
      hi5 = 5'($urandom_range(31, 0));
      case (k)
        0: w = {hi2, did};
        1: w = {hi2, sdid};
        11: w = {hi5, cc};
        default: w = 10'($urandom_range(1023, 0));
      endcase
      send_word(1'b0, w, k == 0, 1'b1);
    end
    repeat ($urandom_range(2, 0)) send_word(1'b0, 10'($urandom_range(1023, 0)), 1'b0, 1'b0);
  endtask

  task automatic directed_part();
    logic [9:0] demo [0:14];
    int k;
    demo = '{10'h261, 10'h101, 10'h000, 10'h3FF, 10'h000, 10'h3FF, 10'h000,
             10'h3FF, 10'h000, 10'h3FF, 10'h000, 10'h3E1, 10'h000, 10'h3FF, 10'h2AA};
    send_word(1'b1, 10'h3FF, 1'b1, 1'b1);
    for (k = 0; k < 15; k++) send_word(1'b0, demo[k], k == 0, 1'b1);
    send_word(1'b0, 10'h155, 1'b0, 1'b0);
    send_word(1'b1, 10'h000, 1'b0, 1'b1);
    send_word(1'b0, 10'h060, 1'b1, 1'b1);
    send_word(1'b0, 10'h101, 1'b0, 1'b1);
    send_word(1'b0, 10'h161, 1'b1, 1'b1);
    send_word(1'b1, 10'h2AA, 1'b0, 1'b1);
    send_word(1'b0, 10'h001, 1'b0, 1'b0);
  endtask

  task automatic long_frame();
    send_word(1'b1, 10'($urandom_range(1023, 0)), 1'($urandom_range(1, 0)), 1'b1);
    hold_request = 1'b1;
    repeat (6) send_packet(cur_did, cur_sdid, 5'd31, -1);
    send_word(1'b1, 10'($urandom_range(1023, 0)), 1'($urandom_range(1, 0)), 1'b1);
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned first;
    int unsigned r;
    int unsigned n;
    logic [7:0] flip;
    logic [4:0] cc;
    logic f;
    first = useful_items;
    while (useful_items - first < budget) begin
      r = $urandom_range(99, 0);
      flip = 8'($urandom_range(255, 1));
      cc = pick_cc();
      if (r < 60) begin
        send_packet(cur_did, cur_sdid, cc, -1);
      end else if (r < 68) begin
        send_packet(cur_did ^ flip, cur_sdid, cc, -1);
      end else if (r < 74) begin
        send_packet(cur_did, cur_sdid ^ flip, cc, -1);
      end else if (r < 84) begin
        send_packet(cur_did, cur_sdid, cc, $urandom_range(11 + 3 * cc, 1));
      end else if (r < 92) begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          f = ($urandom_range(15, 0) == 0);
          send_word(f, 10'($urandom_range(1023, 0)), $urandom_range(3, 0) == 0, f);
        end
      end else begin
        send_word(1'b1, 10'($urandom_range(1023, 0)), 1'($urandom_range(1, 0)), 1'b1);
      end
    end
  endtask

  initial begin : stimulus
    board = new(FRAME_LIMIT);
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= 1'b0;
    in_ch.anc_word <= '0;
    in_ch.packet_start <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr <= '0;
    cfg_ch.data <= '0;
    cur_did = DID_RESET;
    cur_sdid = SDID_RESET;
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed_part();
    drain();

    configure(8'h00, 8'hFF);
    run_phase(200);
    drain();

    configure(8'hFF, 8'h00);
    tx_idle_pct = 8;
    rx_stall_pct = 8;
    long_frame();
    run_phase(100);
    drain();

    configure(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    tx_idle_pct = 25;
    rx_stall_pct = 25;
    run_phase(200);
    drain();

    configure(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    tx_idle_pct = 5;
    rx_stall_pct = 30;
    run_phase(200);
    drain();

    configure(DID_RESET, SDID_RESET);
    quiet = 1'b1;
    run_phase(180);
    drain();

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      if (board.outstanding() != 0)
        $display("%0d results never arrived", board.outstanding());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
